[hdl/frame_duplicate_rate_converter_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the frame duplicate rate converter
// Clocked assertions with synchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef FRAME_DUPLICATE_RATE_CONVERTER_UNIT_ASSERT_SVH
`define FRAME_DUPLICATE_RATE_CONVERTER_UNIT_ASSERT_SVH

// generic form: explicit clock and reset
`define FDRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// house form: i_clk / i_rst_n
`define FDRC_ASSERT_STD(lbl, prop, msg) \
    `FDRC_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

[hdl/fdrc_pkg.sv]
// ----------------------------------------------------------------------------
// fdrc_pkg
// Shared widths, register indexes, reset values and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package fdrc_pkg;

    localparam int TIME_W        = 64;
    localparam int OVH_W         = 32;
    localparam int FREQ_W        = 32;
    localparam int RATE_W        = 24;
    localparam int CNT_W         = 8;
    localparam int PROD_W        = TIME_W + RATE_W;
    localparam int FRAC_BITS_DEF = 16;

    localparam int IN_TDATA_W    = 96;
    localparam int OUT_TDATA_W   = 8;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_FREQ  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_WEIGHT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVH_COMP_ON = 8'd3;

    localparam logic [FREQ_W-1:0] RST_TIMER_FREQ  = 32'd10000000;
    localparam logic [RATE_W-1:0] RST_TARGET_RATE = 24'd1966080;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_COMP,
        S_MUL,
        S_DIV,
        S_ACC,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[hdl/frame_duplicate_rate_converter_unit.sv]
// ----------------------------------------------------------------------------
// frame_duplicate_rate_converter_unit
// Per-frame copy count for frame rate conversion with a Q fraction carry.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one frame request: timer value and capture overhead.
//   m_axis returns one result per request: copy count in tdata, and in tuser
//   a flag set when the frame only stored its timestamp.
//   The cfg channel writes timer_freq, target rate, fixed weight and the
//   overhead compensation enable; it is always ready, write it while idle.
// Timing:
//   One frame is in flight at a time; s_axis_tready is high only when idle.
//   First frame / no time advance: CALC, then DONE.
//   Fixed weight: CALC, ACC, DONE; zero weight: CALC, COMP, ACC, DONE.
//   Measured weight: CALC, COMP, then the serial multiplier (MUL) and the
//   serial divider (DIV), each one bit per cycle, then ACC and DONE.
// Reset clears the frame history, the leftover fraction and the penalty,
// and loads the configuration defaults. A stalled m_axis holds its result
// in the output register while the next frame is taken and computed.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_duplicate_rate_converter_unit #(
    parameter int FRAC_BITS = fdrc_pkg::FRAC_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // stream in: [63:0] now_time, [95:64] overhead_ticks
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [fdrc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // stream out: [7:0] dup_count
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [fdrc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] first_frame
    output logic [0:0]                       m_axis_tuser,
    // configuration writes
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [fdrc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [fdrc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fdrc_pkg::*;

    localparam int QW   = FRAC_BITS + 9;
    localparam int UP   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DOWN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    t_state r_state, n_state;

    // configuration
    logic [FREQ_W-1:0]    r_freq;
    logic [RATE_W-1:0]    r_target;
    logic [RATE_W-1:0]    r_fixed;
    logic                 r_comp_on;

    // frame history
    logic [TIME_W-1:0]    r_last;
    logic [FRAC_BITS-1:0] r_left;
    logic [OVH_W-1:0]     r_pen;

    // working registers
    logic [TIME_W-1:0]    r_now;
    logic [OVH_W-1:0]     r_ovh;
    logic [TIME_W-1:0]    r_d;
    logic [QW-1:0]        r_w;
    logic [CNT_W-1:0]     r_res_count;
    logic                 r_res_first;
    logic                 r_mul_start;

    // output register
    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_out_count;
    logic                 r_out_first;

    logic [TIME_W-1:0]    d_raw;
    logic                 first_cond;
    logic                 fixed_on;
    logic [OVH_W-1:0]     pen_half;
    logic [OVH_W-1:0]     shrink;
    logic [OVH_W-1:0]     pen_decay;
    logic                 nonpos;
    logic                 w_zero;
    logic [RATE_W+15:0]   fx_wide;
    logic [QW-1:0]        sum;
    logic [8:0]           count9;

    logic                 in_ready;
    logic                 out_free;
    logic                 out_load;
    logic                 mul_go;

    logic                 mul_done;
    logic [PROD_W-1:0]    product;
    logic                 div_done;
    logic [QW-1:0]        div_weight;

    // ---------------- datapath combinational ----------------
    assign d_raw      = r_now - r_last;
    // zero history, no advance, or time went backward
    assign first_cond = (r_last == '0) || (d_raw == '0) || d_raw[TIME_W-1];
    assign fixed_on   = (r_fixed != '0);

    assign pen_half   = r_ovh >> 1;
    assign shrink     = r_ovh - pen_half;
    assign pen_decay  = r_pen >> 1;
    assign nonpos     = r_comp_on && (r_ovh != '0) && ({32'd0, shrink} >= r_d);
    assign w_zero     = nonpos || (r_freq == '0);

    assign fx_wide    = ({16'd0, r_fixed} << UP) >> DOWN;
    assign sum        = r_w + QW'(r_left);
    assign count9     = sum[QW-1:FRAC_BITS];

    // ---------------- controller ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_axis_tvalid) n_state = S_CALC;
            S_CALC: begin
                if (first_cond)    n_state = S_DONE;
                else if (fixed_on) n_state = S_ACC;
                else               n_state = S_COMP;
            end
            S_COMP: n_state = w_zero ? S_ACC : S_MUL;
            S_MUL:  if (mul_done) n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_ACC;
            S_ACC:  n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready = (r_state == S_IDLE);
        out_free = !r_out_valid || m_axis_tready;
        out_load = (r_state == S_DONE) && out_free;
        mul_go   = (r_state == S_COMP) && !w_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mul_start <= mul_go;
            if (out_load)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    // configuration and frame history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq    <= RST_TIMER_FREQ;
            r_target  <= RST_TARGET_RATE;
            r_fixed   <= '0;
            r_comp_on <= 1'b0;
            r_last    <= '0;
            r_left    <= '0;
            r_pen     <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TIMER_FREQ:   r_freq    <= i_cfg_data;
                    CFG_TARGET_RATE:  r_target  <= i_cfg_data[RATE_W-1:0];
                    CFG_FIXED_WEIGHT: r_fixed   <= i_cfg_data[RATE_W-1:0];
                    CFG_OVH_COMP_ON:  r_comp_on <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == S_CALC)
                r_last <= r_now;
            if ((r_state == S_COMP) && r_comp_on)
                r_pen <= (r_ovh != '0) ? pen_half : pen_decay;
            if (r_state == S_ACC)
                r_left <= sum[FRAC_BITS-1:0];
        end
    end

    // per-frame payload
    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_now <= s_axis_tdata[TIME_W-1:0];
            r_ovh <= s_axis_tdata[TIME_W+OVH_W-1:TIME_W];
        end
        case (r_state)
            S_CALC: begin
                r_d         <= d_raw;
                r_res_first <= first_cond;
                r_res_count <= CNT_W'(1);
                if (fixed_on)
                    r_w <= QW'(fx_wide);
            end
            S_COMP: begin
                if (w_zero)
                    r_w <= '0;
                if (r_comp_on && !nonpos) begin
                    if (r_ovh != '0)
                        r_d <= r_d - {32'd0, shrink};
                    else
                        r_d <= r_d + {32'd0, pen_decay};
                end
            end
            S_DIV: begin
                if (div_done)
                    r_w <= div_weight;
            end
            S_ACC: begin
                r_res_count <= count9[8] ? {CNT_W{1'b1}} : count9[CNT_W-1:0];
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_count <= r_res_count;
            r_out_first <= r_res_first;
        end
    end

    fdrc_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_mcand   (r_d),
        .i_mplier  (r_target),
        .o_done    (mul_done),
        .o_product (product)
    );

    fdrc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mul_done),
        .i_dividend (product),
        .i_divisor  (r_freq),
        .o_done     (div_done),
        .o_weight   (div_weight)
    );

    assign s_axis_tready = in_ready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_count;
    assign m_axis_tuser  = r_out_first;

endmodule

`default_nettype wire

[hdl/fdrc_mul.sv]
// ----------------------------------------------------------------------------
// fdrc_mul
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdrc_mul (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire [fdrc_pkg::TIME_W-1:0]  i_mcand,
    input  wire [fdrc_pkg::RATE_W-1:0]  i_mplier,
    output logic                        o_done,
    output logic [fdrc_pkg::PROD_W-1:0] o_product
);
    import fdrc_pkg::*;

    localparam int CW = $clog2(RATE_W);

    logic [PROD_W:0]   r_p;
    logic [TIME_W-1:0] r_mcand;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [TIME_W:0]   sum;

    // upper part of the partial product plus the current addend
    assign sum = r_p[PROD_W:RATE_W] + {1'b0, (r_p[0] ? r_mcand : {TIME_W{1'b0}})};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(RATE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p     <= {{(TIME_W + 1){1'b0}}, i_mplier};
            r_mcand <= i_mcand;
        end else if (r_busy) begin
            r_p <= {1'b0, sum, r_p[RATE_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_p[PROD_W-1:0];

endmodule

`default_nettype wire

[hdl/fdrc_div.sv]
// ----------------------------------------------------------------------------
// fdrc_div
// Bit-serial restoring divider with a saturating quotient (cap 256.0).
// ----------------------------------------------------------------------------
`default_nettype none

module fdrc_div #(
    parameter int FRAC_BITS = fdrc_pkg::FRAC_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire [fdrc_pkg::PROD_W-1:0]  i_dividend,
    input  wire [fdrc_pkg::FREQ_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [FRAC_BITS+8:0]        o_weight
);
    import fdrc_pkg::*;

    localparam int UP    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DOWN  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    // dividend bits used MSB first; low DOWN bits dropped, UP zeros appended
    localparam int STEPS = PROD_W - DOWN + UP;
    localparam int CW    = $clog2(STEPS);
    localparam int QW    = FRAC_BITS + 9;
    localparam logic [QW-1:0] CAP = {1'b1, {(FRAC_BITS + 8){1'b0}}};

    logic [PROD_W-1:0] r_dvd;
    logic [FREQ_W-1:0] r_dsr;
    logic [FREQ_W-1:0] r_rem;
    logic [QW-1:0]     r_q;
    logic              r_sat;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [FREQ_W:0]   trial;
    logic [FREQ_W:0]   diff;
    logic              ge;

    assign trial = {r_rem, r_dvd[PROD_W-1]};
    assign ge    = (trial >= {1'b0, r_dsr});
    assign diff  = trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
            r_q   <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[PROD_W-2:0], 1'b0};
            r_rem <= ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
            r_q   <= {r_q[QW-2:0], ge};
            // sticky: any quotient bit pushed out means far above the cap
            r_sat <= r_sat | r_q[QW-1];
        end
    end

    assign o_done   = r_done;
    assign o_weight = (r_sat || (r_q > CAP)) ? CAP : r_q;

endmodule

`default_nettype wire

[hdl/fdrc_checker.sv]
// ----------------------------------------------------------------------------
// fdrc_checker
// Port-level checks of the frame duplicate rate converter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_duplicate_rate_converter_unit_assert.svh"

module fdrc_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       s_axis_tvalid,
    input wire       s_axis_tready,
    input wire       m_axis_tvalid,
    input wire       m_axis_tready,
    input wire [7:0] m_axis_tdata,
    input wire [0:0] m_axis_tuser
);

    // one frame in flight: no new request right after one is taken
    `FDRC_ASSERT_STD(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request accepted back to back")

    // a stored-timestamp result always asks for exactly one copy
    `FDRC_ASSERT_STD(a_first_is_one, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'd1, "first frame result not one copy")

    // no result can appear in the cycle right after a request
    `FDRC_ASSERT_STD(a_min_latency, s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid), "result too early after request")

    // stalled result holds
    `FDRC_ASSERT_STD(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind frame_duplicate_rate_converter_unit fdrc_checker u_fdrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
